// File: hdl/blri_pkg.sv
`timescale 1ns / 1ps

package blri_pkg;

	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int DEPTH_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DUMP   = 2'd2
	} op_t;

	typedef struct packed {
		logic load;
		logic wrap;
		logic shift;
	} blri_cell_ctl_t;

endpackage

// File: hdl/bounded_list_insert_remove_core.sv
// Insert loads the value into the cell at the tail; remove rotates the list once
// through the row of cells past the head comparator. A dump also rotates the list once and
// gives one word per cycle while out_ready is high, or one flagged word for an empty list.
// The block takes a new word in the cycle after an insert, and after a remove or dump completes.
// Asynchronous reset empties the list and sets capacity to 16; the entry cells are not cleared.
`timescale 1ns / 1ps

module bounded_list_insert_remove_core
	import blri_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         capacity,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] item_value,
	output logic                     last_item,
	output logic                     list_empty
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_DUMP
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   capacity_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   steps_q;
	logic [DATA_W-1:0]  key_q;
	logic               found_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  item_value_q;
	logic               last_item_q;
	logic               list_empty_q;

	logic               in_fire;
	logic               out_free;
	logic               ins_ok;
	logic               do_insert;
	logic               rot_step;
	logic               drop;
	logic [DATA_W-1:0]  head;
	logic [DATA_W-1:0]  cell_data [DEPTH];

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign head       = cell_data[0];

	assign ins_ok    = (CMP_W'(count_q) < CMP_W'(capacity_q)) &&
	                   (CMP_W'(count_q) < CMP_W'(DEPTH));
	assign do_insert = in_fire && (operation == OP_INSERT) && ins_ok;
	assign drop      = (state_q == ST_REMOVE) && !found_q && (head == key_q);
	assign rot_step  = (state_q == ST_REMOVE) ||
	                   ((state_q == ST_DUMP) && out_free && (count_q != '0));

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX    = CNT_W'(i);
		localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(i + 1);
		blri_cell_ctl_t    ctl;
		logic [DATA_W-1:0] right;

		assign ctl.load  = do_insert && (IDX == count_q);
		assign ctl.wrap  = rot_step && !drop && (IDX_P1 == count_q);
		assign ctl.shift = rot_step && (IDX_P1 < count_q);

		if (i == DEPTH - 1) begin : g_tail
			assign right = cell_data[i];
		end else begin : g_mid
			assign right = cell_data[i + 1];
		end

		blri_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.right     (right),
			.head      (head),
			.load_data (value),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			capacity_q   <= CAP_RESET;
			count_q      <= '0;
			steps_q      <= '0;
			key_q        <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			item_value_q <= '0;
			last_item_q  <= 1'b0;
			list_empty_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= capacity;
			end
			if ((state_q == ST_DUMP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (operation)
							OP_INSERT: begin
								if (ins_ok) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_REMOVE: begin
								if (count_q != '0) begin
									state_q <= ST_REMOVE;
									steps_q <= count_q;
									key_q   <= value;
									found_q <= 1'b0;
								end
							end
							OP_DUMP: begin
								state_q <= ST_DUMP;
								steps_q <= count_q;
							end
							default: begin
							end
						endcase
					end
				end
				ST_REMOVE: begin
					steps_q <= steps_q - CNT_W'(1);
					if (drop) begin
						count_q <= count_q - CNT_W'(1);
						found_q <= 1'b1;
					end
					if (steps_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						if (count_q == '0) begin
							item_value_q <= '0;
							last_item_q  <= 1'b1;
							list_empty_q <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							item_value_q <= head;
							last_item_q  <= (steps_q == CNT_W'(1));
							list_empty_q <= 1'b0;
							steps_q      <= steps_q - CNT_W'(1);
							if (steps_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign item_value = item_value_q;
	assign last_item  = last_item_q;
	assign list_empty = list_empty_q;

endmodule

// File: hdl/blri_cell.sv
`timescale 1ns / 1ps

module blri_cell
	import blri_pkg::*;
(
	input  logic                clk,
	input  blri_cell_ctl_t      ctl,
	input  logic [DATA_W-1:0]   right,
	input  logic [DATA_W-1:0]   head,
	input  logic [DATA_W-1:0]   load_data,
	output logic [DATA_W-1:0]   data
);

	logic [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			val_q <= load_data;
		end else if (ctl.wrap) begin
			val_q <= head;
		end else if (ctl.shift) begin
			val_q <= right;
		end else begin
			val_q <= val_q;
		end
	end

	assign data = val_q;

endmodule

// File: hdl/blri_checker.sv
`timescale 1ns / 1ps

module blri_checker
	import blri_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [1:0]               operation,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] item_value,
	input logic                     last_item,
	input logic                     list_empty
);

	// A waiting result word stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(item_value) && $stable(last_item) &&
		$stable(list_empty))
		else $error("stalled result word changed");

	// A word flagged as an empty dump must be zero and must also be the last.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_empty |-> last_item && (item_value == '0))
		else $error("empty dump word malformed");

	// A dump holds off new words while its results are produced.
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_DUMP) |=> !in_ready)
		else $error("new word taken during a dump");

endmodule

bind bounded_list_insert_remove_core blri_checker u_blri_checker (.*);

// File: bench/tb_bounded_list_insert_remove_core.sv
`timescale 1ns / 1ps

module tb_bounded_list_insert_remove_core;
	import blri_pkg::*;

	localparam logic [1:0]  OP_NONE     = 2'd3;
	localparam logic [31:0] MOST_NEG    = 32'h8000_0000;
	localparam logic [31:0] MOST_POS    = 32'h7fff_ffff;
	localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
	localparam int          SETTLE      = 40;
	localparam int          QUIET_LIMIT = 1000;
	localparam int          HOLD_CYCLES = 150;
	localparam int          PRESS_PHASE = 4;
	localparam int          PHASE_WORDS = 4;
	localparam int          N_DIRECTED  = 19;
	localparam int          N_PHASES    = 7;

	typedef struct packed {
		logic signed [DATA_W-1:0] item_value;
		logic                     last_item;
		logic                     list_empty;
	} dump_word_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] val;
		logic        fixed;
		logic [31:0] f_value;
		logic        f_last;
		logic        f_empty;
	} dir_row_t;

	// Rows marked fixed carry the dump word read straight off the spec.
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{OP_DUMP,   32'd0,        1'b1, 32'd0,    1'b1, 1'b1},
		'{OP_NONE,   ALL_ONES,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_REMOVE, 32'd5,        1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_INSERT, MOST_NEG,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_DUMP,   ALL_ONES,     1'b1, MOST_NEG, 1'b1, 1'b0},
		'{OP_INSERT, MOST_POS,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_INSERT, 32'd0,        1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_INSERT, ALL_ONES,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_INSERT, MOST_POS,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_DUMP,   32'd0,        1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_REMOVE, MOST_POS,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_DUMP,   32'd0,        1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_REMOVE, 32'h0001_2345, 1'b0, 32'd0,   1'b0, 1'b0},
		'{OP_REMOVE, ALL_ONES,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_REMOVE, MOST_NEG,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_DUMP,   32'd0,        1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_REMOVE, 32'd0,        1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_REMOVE, MOST_POS,     1'b0, 32'd0,    1'b0, 1'b0},
		'{OP_DUMP,   32'd0,        1'b1, 32'd0,    1'b1, 1'b1}
	};

	localparam int PH_CAP  [N_PHASES] = '{31, 1, 0, 5, 16, 2, 16};
	localparam int PH_MODE [N_PHASES] = '{0, 1, 2, 3, 0, 2, 1};
	localparam int PH_FILL [N_PHASES] = '{18, 0, 0, 0, 16, 0, 0};

	logic                     clk;
	logic                     arst_n     = 1'b0;
	logic                     cfg_valid  = 1'b0;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         capacity   = CAP_RESET;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic [1:0]               operation  = OP_INSERT;
	logic signed [DATA_W-1:0] value      = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic signed [DATA_W-1:0] item_value;
	logic                     last_item;
	logic                     list_empty;

	logic [31:0]      list_mem [DEPTH_DEF];
	int               list_len = 0;
	logic [CAP_W-1:0] cap_reg  = CAP_RESET;
	dump_word_t       dump_q[$];
	dump_word_t       want;
	int               errors   = 0;
	int               quiet    = 0;
	int               idle_mode = 0;
	int               hold_req_n = 0;
	int               hold_ack_n = 0;
	int               hold_left  = 0;

	bounded_list_insert_remove_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (capacity),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_value (item_value),
		.last_item  (last_item),
		.list_empty (list_empty)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Updates the list copy for one accepted word and queues the dump words it yields.
	// Returns 1 when the word changed the list or produced output.
	function automatic bit apply_to_list(input logic [1:0] op, input logic [31:0] v);
		int lim;
		int pos;
		lim = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
		case (op)
			OP_INSERT: begin
				if (list_len < lim) begin
					list_mem[list_len] = v;
					list_len++;
					return 1'b1;
				end
			end
			OP_REMOVE: begin
				pos = 0;
				while (pos < list_len && list_mem[pos] != v)
					pos++;
				if (pos < list_len) begin
					for (int k = pos; k < list_len - 1; k++)
						list_mem[k] = list_mem[k + 1];
					list_len--;
					return 1'b1;
				end
			end
			OP_DUMP: begin
				if (list_len == 0)
					dump_q.push_back('{'0, 1'b1, 1'b1});
				else
					for (int k = 0; k < list_len; k++)
						dump_q.push_back('{list_mem[k], k == list_len - 1, 1'b0});
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom;
		if (r < 80)
			return $urandom_range(7);
		case ($urandom_range(2))
			0: return MOST_NEG;
			1: return MOST_POS;
			default: return ALL_ONES;
		endcase
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [31:0] v);
		int rest;
		rest = (idle_mode == 1) ? 52 : (idle_mode == 3) ? 12 : 0;
		while ($urandom_range(99) < rest) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value     <= v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (dump_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(input int c);
		cfg_valid <= 1'b1;
		capacity  <= c[CAP_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cap_reg = c[CAP_W-1:0];
	endtask

	always @(negedge clk) begin
		int stall;
		stall = (idle_mode == 2) ? 52 : (idle_mode == 3) ? 12 : 0;
		if (hold_left == 0 && hold_ack_n != hold_req_n) begin
			hold_ack_n = hold_req_n;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (dump_q.size() == 0) begin
				$error("output word with no dump pending: item_value %0d", item_value);
				errors++;
			end else begin
				want = dump_q.pop_front();
				if (item_value !== want.item_value) begin
					$error("item_value: expected %0d, got %0d", want.item_value, item_value);
					errors++;
				end
				if (last_item !== want.last_item) begin
					$error("last_item: expected %0b, got %0b", want.last_item, last_item);
					errors++;
				end
				if (list_empty !== want.list_empty) begin
					$error("list_empty: expected %0b, got %0b", want.list_empty, list_empty);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_bounded_list_insert_remove_core failed");
			$finish;
		end
	end

	initial begin
		logic [1:0]  op;
		logic [31:0] v;
		int          done;
		int          r;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			send_word(DIRECTED[i].op, DIRECTED[i].val);
			if (DIRECTED[i].fixed)
				dump_q.push_back('{DIRECTED[i].f_value, DIRECTED[i].f_last,
					DIRECTED[i].f_empty});
			else
				void'(apply_to_list(DIRECTED[i].op, DIRECTED[i].val));
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_capacity(PH_CAP[p]);
			idle_mode = PH_MODE[p];
			for (int k = 0; k < PH_FILL[p]; k++) begin
				v = pick_value();
				send_word(OP_INSERT, v);
				void'(apply_to_list(OP_INSERT, v));
			end
			if (p == PRESS_PHASE) begin
				// The receiver stops taking words while dumps keep arriving.
				hold_req_n++;
				repeat (6) begin
					send_word(OP_DUMP, $urandom);
					void'(apply_to_list(OP_DUMP, 32'd0));
				end
			end
			done = 0;
			while (done < PHASE_WORDS) begin
				r = $urandom_range(99);
				op = (r < 45) ? OP_INSERT : (r < 75) ? OP_REMOVE : (r < 93) ? OP_DUMP : OP_NONE;
				if (op == OP_REMOVE && list_len > 0 && $urandom_range(99) < 70)
					v = list_mem[$urandom_range(list_len - 1)];
				else if (op == OP_DUMP || op == OP_NONE)
					v = $urandom;
				else
					v = pick_value();
				send_word(op, v);
				if (apply_to_list(op, v))
					done++;
			end
		end

		in_valid <= 1'b0;
		while (dump_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb_bounded_list_insert_remove_core passed");
		else
			$display("tb_bounded_list_insert_remove_core failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/blri_pkg.sv
hdl/blri_cell.sv
hdl/bounded_list_insert_remove_core.sv
hdl/blri_checker.sv
bench/tb_bounded_list_insert_remove_core.sv
